[sv/sfc_pkg.sv]
// Shared types and fixed field widths for the size class free list cache.
// No dependencies; imported by size_class_free_list_cache_top and its testbench.
package sfc_pkg;

    localparam int ADDR_W = 48;
    localparam int SIZE_W = 32;
    localparam int REQ_W  = 33;

    // The class of a size is (size - 1) >> 6, taken one bit wider than the size
    // so that size zero lands beyond every class of a nonzero size.
    localparam int CLASS_W = SIZE_W + 1 - 6;

    typedef enum logic [2:0] {
        ACT_KEEP     = 3'd0,
        ACT_CACHED   = 3'd1,
        ACT_SYS_REAL = 3'd2,
        ACT_CFREE    = 3'd3,
        ACT_SYS_FREE = 3'd4,
        ACT_NOTHING  = 3'd5
    } t_action;

endpackage

[sv/size_class_free_list_cache_top.sv]
// Size class free list cache: one ring of freed addresses per 64-byte size class.
// Depends on sfc_pkg for the action codes and the fixed field widths.
//
//   channel   direction  handshake                  payload
//   request   in         i_in_valid / o_in_ready    old address, present, old size, new size
//   result    out        o_out_valid / i_out_ready  action, address, release, copy, request
//
// A request transaction runs through the states S_IDLE and S_CALC: the accept cycle
// reads both counter memories, S_CALC decides and writes back counters and the ring memory.
// A request that takes a cached block also passes through S_POP to bring the ring read into the result.
// Reset clears the counter valid bits, the state and the result valid; ring entries are never cleared.
// A stalled result holds the block in its decision cycle; no write happens until
// the result register can take the new transaction.
module size_class_free_list_cache_top #(
    parameter int CLASSES   = 16,
    parameter int SLOTS     = 1024,
    parameter int ADDR_BITS = 48
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic [sfc_pkg::ADDR_W-1:0]    i_old_address,
    input  logic                          i_old_present,
    input  logic [sfc_pkg::SIZE_W-1:0]    i_old_size,
    input  logic [sfc_pkg::SIZE_W-1:0]    i_new_size,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output sfc_pkg::t_action              o_action,
    output logic [sfc_pkg::ADDR_W-1:0]    o_result_address,
    output logic                          o_release_old,
    output logic [sfc_pkg::SIZE_W-1:0]    o_copy_bytes,
    output logic [sfc_pkg::REQ_W-1:0]     o_request_size
);
    import sfc_pkg::*;

    // Stored address width: the masked address never has more than 48 live bits.
    localparam int AB         = (ADDR_BITS < ADDR_W) ? ADDR_BITS : ADDR_W;
    localparam int CLW        = (CLASSES > 1) ? $clog2(CLASSES) : 1;
    localparam int CW         = $clog2(2 * SLOTS);
    localparam int SW         = $clog2(SLOTS);
    localparam int RING_DEPTH = CLASSES * SLOTS;
    localparam int AW         = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;

    localparam logic [CW:0]        COUNT_MOD  = (CW + 1)'(2 * SLOTS);
    localparam logic [CW:0]        SLOTS_C    = (CW + 1)'(SLOTS);
    localparam logic [CW-1:0]      COUNT_LAST = CW'(2 * SLOTS - 1);
    localparam logic [AW-1:0]      SLOTS_A    = AW'(SLOTS);
    localparam logic [CLASS_W-1:0] CLASSES_C  = CLASS_W'(CLASSES);
    localparam logic [ADDR_W-1:0]  ADDR_MASK  = ADDR_W'((49'd1 << AB) - 49'd1);

    typedef enum logic [1:0] {
        S_IDLE,
        S_CALC,
        S_POP
    } t_state;

    function automatic logic [CW-1:0] count_next(input logic [CW-1:0] c);
        return (c == COUNT_LAST) ? '0 : c + 1'b1;
    endfunction

    function automatic logic [SW-1:0] count_slot(input logic [CW-1:0] c);
        logic [CW:0] w;
        w = {1'b0, c};
        return (w >= SLOTS_C) ? SW'(w - SLOTS_C) : SW'(w);
    endfunction

    // Number of addresses held: (write - read) modulo twice the ring size.
    function automatic logic [CW:0] ring_fill(input logic [CW-1:0] wr, input logic [CW-1:0] rd);
        return (wr >= rd) ? ({1'b0, wr} - {1'b0, rd}) : ({1'b0, wr} + COUNT_MOD - {1'b0, rd});
    endfunction

    // ---------------------------------------------------------------------
    // Storage: ring memory, read and write count memories with valid bits.
    // ---------------------------------------------------------------------
    logic [AB-1:0]      r_ring [RING_DEPTH];
    logic [AB-1:0]      r_ring_q;
    logic [CW-1:0]      r_rd_mem [CLASSES];
    logic [CW-1:0]      r_wr_mem [CLASSES];
    logic [CLASSES-1:0] r_rd_vld;
    logic [CLASSES-1:0] r_wr_vld;

    // Registered counter reads for the old and the new class.
    logic [CW-1:0] r_orc_q, r_owc_q, r_nrc_q, r_nwc_q;
    logic          r_orc_v, r_owc_v, r_nrc_v, r_nwc_v;

    // Request held for the decision cycle.
    logic [ADDR_W-1:0] r_old_addr;
    logic              r_old_present;
    logic [SIZE_W-1:0] r_old_size;
    logic [SIZE_W-1:0] r_new_size;
    logic              r_free;
    logic              r_same;
    logic              r_oc_ok;
    logic              r_nc_ok;
    logic [CLW-1:0]    r_oc_idx;
    logic [CLW-1:0]    r_nc_idx;
    logic [AW-1:0]     r_oc_base;
    logic [AW-1:0]     r_nc_base;
    logic [REQ_W-1:0]  r_req_size;

    t_state             r_state, n_state;
    logic               r_out_valid, n_out_valid;
    t_action            r_action, n_action;
    logic [ADDR_W-1:0]  r_res_addr, n_res_addr;
    logic               r_release, n_release;
    logic [SIZE_W-1:0]  r_copy, n_copy;
    logic [REQ_W-1:0]   r_request, n_request;

    // ---------------------------------------------------------------------
    // Accept cycle: classify both sizes and address the counter memories.
    // ---------------------------------------------------------------------
    logic               in_acc;
    logic [SIZE_W:0]    old_dec, new_dec;
    logic [CLASS_W-1:0] oc_full, nc_full;
    logic               oc_ok, nc_ok;
    logic [CLW-1:0]     oc_idx, nc_idx;
    logic [CLASS_W-1:0] nc_inc;

    assign o_in_ready = (r_state == S_IDLE);
    assign in_acc     = i_in_valid && o_in_ready;

    always_comb begin
        old_dec = {1'b0, i_old_size} - 1'b1;
        new_dec = {1'b0, i_new_size} - 1'b1;
        oc_full = old_dec[SIZE_W:6];
        nc_full = new_dec[SIZE_W:6];
        oc_ok   = (oc_full < CLASSES_C);
        nc_ok   = (nc_full < CLASSES_C);
        oc_idx  = oc_ok ? oc_full[CLW-1:0] : '0;
        nc_idx  = nc_ok ? nc_full[CLW-1:0] : '0;
        // A nonzero size has a class below 2^26, so the top bit is dropped here.
        nc_inc  = {1'b0, nc_full[CLASS_W-2:0]} + 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_old_addr    <= i_old_address & ADDR_MASK;
            r_old_present <= i_old_present;
            r_old_size    <= i_old_size;
            r_new_size    <= i_new_size;
            r_free        <= (i_new_size == '0);
            r_same        <= (oc_full == nc_full);
            r_oc_ok       <= oc_ok;
            r_nc_ok       <= nc_ok;
            r_oc_idx      <= oc_idx;
            r_nc_idx      <= nc_idx;
            r_oc_base     <= AW'(oc_idx) * SLOTS_A;
            r_nc_base     <= AW'(nc_idx) * SLOTS_A;
            r_req_size    <= {nc_inc, 6'b0};
            r_orc_q       <= r_rd_mem[oc_idx];
            r_owc_q       <= r_wr_mem[oc_idx];
            r_nrc_q       <= r_rd_mem[nc_idx];
            r_nwc_q       <= r_wr_mem[nc_idx];
            r_orc_v       <= r_rd_vld[oc_idx];
            r_owc_v       <= r_wr_vld[oc_idx];
            r_nrc_v       <= r_rd_vld[nc_idx];
            r_nwc_v       <= r_wr_vld[nc_idx];
        end
    end

    // ---------------------------------------------------------------------
    // Decision cycle: ring fill checks, pop of the new class, push of the old.
    // ---------------------------------------------------------------------
    logic [CW-1:0] orc, owc, nrc, nwc;
    logic          oc_is_full, nc_empty, push_ok;
    logic          out_free, commit;
    logic          do_push, do_pop;
    t_action       calc_action;
    logic [ADDR_W-1:0] calc_addr;
    logic          calc_release;
    logic [SIZE_W-1:0] calc_copy;
    logic [REQ_W-1:0]  calc_req;

    always_comb begin
        // A count never written reads as zero.
        orc        = r_orc_v ? r_orc_q : '0;
        owc        = r_owc_v ? r_owc_q : '0;
        nrc        = r_nrc_v ? r_nrc_q : '0;
        nwc        = r_nwc_v ? r_nwc_q : '0;
        oc_is_full = (ring_fill(owc, orc) >= SLOTS_C);
        nc_empty   = (nwc == nrc);
        push_ok    = r_oc_ok && !oc_is_full;

        do_push      = 1'b0;
        do_pop       = 1'b0;
        calc_action  = ACT_NOTHING;
        calc_addr    = '0;
        calc_release = 1'b0;
        calc_copy    = '0;
        calc_req     = '0;
        if (r_free) begin
            if (r_old_present) begin
                do_push     = push_ok;
                calc_action = push_ok ? ACT_CFREE : ACT_SYS_FREE;
            end
        end else if (r_old_present && r_same) begin
            calc_action = ACT_KEEP;
            calc_addr   = r_old_addr;
        end else if (r_nc_ok && !nc_empty) begin
            do_pop      = 1'b1;
            calc_action = ACT_CACHED;
            if (r_old_present) begin
                do_push      = push_ok;
                calc_release = !push_ok;
                calc_copy    = (r_old_size < r_new_size) ? r_old_size : r_new_size;
            end
        end else begin
            calc_action = ACT_SYS_REAL;
            calc_req    = r_req_size;
        end
    end

    assign out_free = !r_out_valid || i_out_ready;
    assign commit   = (r_state == S_CALC) && out_free;

    // The pop touches the new class and the push the old one; they are never
    // the same class, so each count memory sees at most one write.
    always_ff @(posedge i_clk) begin
        if (commit && do_push) begin
            r_ring[r_oc_base + AW'(count_slot(owc))] <= r_old_addr[AB-1:0];
            r_wr_mem[r_oc_idx] <= count_next(owc);
        end
        if (commit && do_pop) begin
            r_ring_q <= r_ring[r_nc_base + AW'(count_slot(nrc))];
            r_rd_mem[r_nc_idx] <= count_next(nrc);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_vld <= '0;
            r_wr_vld <= '0;
        end else begin
            if (commit && do_push) begin
                r_wr_vld[r_oc_idx] <= 1'b1;
            end
            if (commit && do_pop) begin
                r_rd_vld[r_nc_idx] <= 1'b1;
            end
        end
    end

    // ---------------------------------------------------------------------
    // Sequencer and result register.
    // ---------------------------------------------------------------------
    logic [ADDR_W-1:0] ring_addr_ext;

    always_comb begin
        ring_addr_ext          = '0;
        ring_addr_ext[AB-1:0]  = r_ring_q;

        n_state     = r_state;
        n_out_valid = r_out_valid && !i_out_ready;
        n_action    = r_action;
        n_res_addr  = r_res_addr;
        n_release   = r_release;
        n_copy      = r_copy;
        n_request   = r_request;
        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_state = S_CALC;
                end
            end
            S_CALC: begin
                if (out_free) begin
                    n_action   = calc_action;
                    n_res_addr = calc_addr;
                    n_release  = calc_release;
                    n_copy     = calc_copy;
                    n_request  = calc_req;
                    if (do_pop) begin
                        n_state = S_POP;
                    end else begin
                        n_state     = S_IDLE;
                        n_out_valid = 1'b1;
                    end
                end
            end
            S_POP: begin
                n_res_addr  = ring_addr_ext;
                n_out_valid = 1'b1;
                n_state     = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            r_action    <= n_action;
            r_res_addr  <= n_res_addr;
            r_release   <= n_release;
            r_copy      <= n_copy;
            r_request   <= n_request;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_action         = r_action;
    assign o_result_address = r_res_addr;
    assign o_release_old    = r_release;
    assign o_copy_bytes     = r_copy;
    assign o_request_size   = r_request;

    // ---------------------------------------------------------------------
    // Assertions.
    // ---------------------------------------------------------------------
    a_pop_slot_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_POP) |-> !r_out_valid)
        else $error("ring read landed while the result register was occupied");

    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> !in_acc)
        else $error("request accepted while another was still being decided");

    a_pop_push_apart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (commit && do_pop && do_push) |-> (r_oc_idx != r_nc_idx))
        else $error("pop and push hit the same class in one transaction");

    a_release_cached: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_release) |-> (r_action == ACT_CACHED))
        else $error("release flag set outside a cached block result");

    a_request_sys: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_request != '0)) |-> (r_action == ACT_SYS_REAL))
        else $error("request size given outside a system realloc result");

endmodule

[verif/tb_size_class_free_list_cache_top.sv]
// Self-checking testbench for size_class_free_list_cache_top: directed table, then random traffic.
// Depends on sfc_pkg and the RTL only; predicts every result with its own ring model.
module tb_size_class_free_list_cache_top;
    timeunit 1ns;
    timeprecision 1ps;

    import sfc_pkg::*;

    localparam int CLASSES      = 16;
    localparam int SLOTS        = 1024;
    localparam int CYCLE_LIMIT  = 600000;
    localparam int DRAIN_CYCLES = 16;
    localparam int MIXED_ITEMS  = 50;

    // One request transaction and the result it should produce.
    typedef struct {
        logic [ADDR_W-1:0] addr;
        logic              present;
        logic [SIZE_W-1:0] old_size;
        logic [SIZE_W-1:0] new_size;
    } t_alloc_request;

    typedef struct {
        t_action           action;
        logic [ADDR_W-1:0] addr;
        logic              release_old;
        logic [SIZE_W-1:0] copy_bytes;
        logic [REQ_W-1:0]  request_size;
    } t_alloc_outcome;

    // A directed row carries a typed-in outcome only where it is obvious by inspection.
    typedef struct {
        t_alloc_request req;
        bit             typed;
        t_alloc_outcome outcome;
    } t_directed_row;

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              i_in_valid = 1'b0;
    logic              o_in_ready;
    logic [ADDR_W-1:0] i_old_address = '0;
    logic              i_old_present = 1'b0;
    logic [SIZE_W-1:0] i_old_size = '0;
    logic [SIZE_W-1:0] i_new_size = '0;
    logic              o_out_valid;
    logic              i_out_ready = 1'b0;
    t_action           o_action;
    logic [ADDR_W-1:0] o_result_address;
    logic              o_release_old;
    logic [SIZE_W-1:0] o_copy_bytes;
    logic [REQ_W-1:0]  o_request_size;

    size_class_free_list_cache_top #(
        .CLASSES  (CLASSES),
        .SLOTS    (SLOTS),
        .ADDR_BITS(ADDR_W)
    ) u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_old_address   (i_old_address),
        .i_old_present   (i_old_present),
        .i_old_size      (i_old_size),
        .i_new_size      (i_new_size),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_action        (o_action),
        .o_result_address(o_result_address),
        .o_release_old   (o_release_old),
        .o_copy_bytes    (o_copy_bytes),
        .o_request_size  (o_request_size)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // Shadow copy of the per-class free rings. Each ring is a circular buffer
    // with a head pointer and a fill count; an entry is read only after a push.
    logic [ADDR_W-1:0] freed_addr_mem [0:CLASSES*SLOTS-1];
    int                ring_head [CLASSES];
    int                ring_fill [CLASSES];

    t_alloc_outcome    expected_outcomes[$];
    t_directed_row     directed_rows[$];
    int                error_count = 0;
    int unsigned       cycle_count = 0;
    bit                no_idle = 1'b0;
    int                ready_hold = 0;
    t_alloc_outcome    oldest;

    // Class of a byte size, one bit wider than the size so that size zero
    // wraps far beyond the class of any nonzero size.
    function automatic logic [SIZE_W:0] size_class(input logic [SIZE_W-1:0] size);
        return ({1'b0, size} - 1'b1) >> 6;
    endfunction

    // Caches an address in its class ring; false when the class has no ring or it is full.
    function automatic bit stash_freed(input logic [SIZE_W:0] cls, input logic [ADDR_W-1:0] addr);
        int c;
        if (cls >= CLASSES)
            return 1'b0;
        c = int'(cls);
        if (ring_fill[c] >= SLOTS)
            return 1'b0;
        freed_addr_mem[c*SLOTS + (ring_head[c] + ring_fill[c]) % SLOTS] = addr;
        ring_fill[c]++;
        return 1'b1;
    endfunction

    // Computes the result of one accepted request and advances the shadow rings.
    function automatic t_alloc_outcome predict_outcome(input t_alloc_request r);
        t_alloc_outcome   o;
        logic [SIZE_W:0]  old_cls;
        logic [SIZE_W:0]  new_cls;
        int               c;
        o.action       = ACT_NOTHING;
        o.addr         = '0;
        o.release_old  = 1'b0;
        o.copy_bytes   = '0;
        o.request_size = '0;
        old_cls = size_class(r.old_size);
        new_cls = size_class(r.new_size);
        if (r.new_size == '0) begin
            if (r.present)
                o.action = stash_freed(old_cls, r.addr) ? ACT_CFREE : ACT_SYS_FREE;
        end else if (r.present && old_cls == new_cls) begin
            o.action = ACT_KEEP;
            o.addr   = r.addr;
        end else if (new_cls < CLASSES && ring_fill[int'(new_cls)] != 0) begin
            c = int'(new_cls);
            o.action     = ACT_CACHED;
            o.addr       = freed_addr_mem[c*SLOTS + ring_head[c]];
            ring_head[c] = (ring_head[c] + 1) % SLOTS;
            ring_fill[c]--;
            // The old block goes back into its own ring when it fits there.
            if (r.present) begin
                o.copy_bytes  = (r.old_size < r.new_size) ? r.old_size : r.new_size;
                o.release_old = !stash_freed(old_cls, r.addr);
            end
        end else begin
            o.action       = ACT_SYS_REAL;
            o.request_size = REQ_W'(new_cls + 1'b1) << 6;
        end
        return o;
    endfunction

    // Idle lengths: mostly none or short, now and then long.
    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 55)
            return 0;
        else if (roll < 90)
            return $urandom_range(1, 3);
        return $urandom_range(4, 40);
    endfunction

    function automatic logic [ADDR_W-1:0] rand_addr();
        logic [63:0] w;
        w = {$urandom, $urandom};
        return w[ADDR_W-1:0];
    endfunction

    function automatic logic [SIZE_W-1:0] rand_size_in_class(input int cls);
        return SIZE_W'(cls * 64 + $urandom_range(1, 64));
    endfunction

    // Biased toward one hot class so that its ring fills and drains.
    function automatic int pick_class(input int hot);
        return ($urandom_range(0, 99) < 40) ? hot : $urandom_range(0, CLASSES - 1);
    endfunction

    // Mixed traffic: frees, same-class keeps, reallocations into cached classes
    // and fully random sizes that often fall outside every class.
    function automatic t_alloc_request random_request(input int hot);
        t_alloc_request r;
        int             roll;
        r.addr    = rand_addr();
        r.present = ($urandom_range(0, 9) != 0);
        roll = $urandom_range(0, 99);
        if (roll < 80)
            r.old_size = rand_size_in_class(pick_class(hot));
        else if (roll < 90)
            r.old_size = $urandom;
        else if (roll < 95)
            r.old_size = '0;
        else
            r.old_size = SIZE_W'($urandom_range(CLASSES * 64 + 1, 2 * CLASSES * 64));
        roll = $urandom_range(0, 99);
        if (roll < 35)
            r.new_size = '0;
        else if (roll < 45)
            r.new_size = (r.old_size == '0) ? SIZE_W'(1)
                : (((r.old_size - 1'b1) & ~SIZE_W'(63)) + SIZE_W'($urandom_range(1, 63)));
        else if (roll < 88)
            r.new_size = rand_size_in_class(pick_class(hot));
        else
            r.new_size = $urandom;
        return r;
    endfunction

    function automatic void add_row(input logic [ADDR_W-1:0] addr, input logic present,
                                    input logic [SIZE_W-1:0] old_size,
                                    input logic [SIZE_W-1:0] new_size, input bit typed,
                                    input t_action action, input logic [ADDR_W-1:0] res_addr,
                                    input logic [REQ_W-1:0] req_size);
        t_directed_row row;
        row.req.addr             = addr;
        row.req.present          = present;
        row.req.old_size         = old_size;
        row.req.new_size         = new_size;
        row.typed                = typed;
        row.outcome.action       = action;
        row.outcome.addr         = res_addr;
        row.outcome.release_old  = 1'b0;
        row.outcome.copy_bytes   = '0;
        row.outcome.request_size = req_size;
        directed_rows.push_back(row);
    endfunction

    // Drives one request, holding valid and the payload until the block takes it.
    // The prediction is made at acceptance, so the expected order is the accept order.
    task automatic send_request(input t_alloc_request r, input bit typed,
                                input t_alloc_outcome typed_outcome);
        int             gap;
        t_alloc_outcome predicted;
        gap = no_idle ? 0 : pick_gap();
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid    <= 1'b1;
        i_old_address <= r.addr;
        i_old_present <= r.present;
        i_old_size    <= r.old_size;
        i_new_size    <= r.new_size;
        @(posedge i_clk);
        while (!o_in_ready)
            @(posedge i_clk);
        // The predictor always runs so that the shadow rings stay in step.
        predicted = predict_outcome(r);
        expected_outcomes.push_back(typed ? typed_outcome : predicted);
    endtask

    // Lowers valid and holds off until every outstanding result has come back.
    task automatic wait_all_results();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (expected_outcomes.size() != 0)
            @(posedge i_clk);
    endtask

    // Result side: check each accepted transaction against the oldest expectation,
    // then pick the next ready level and how long to hold it.
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (expected_outcomes.size() == 0) begin
                $error("result transaction arrived with no request outstanding");
                error_count++;
            end else begin
                oldest = expected_outcomes.pop_front();
                if (o_action !== oldest.action) begin
                    $error("action: expected %0d, got %0d", oldest.action, o_action);
                    error_count++;
                end
                if (o_result_address !== oldest.addr) begin
                    $error("result_address: expected %h, got %h", oldest.addr, o_result_address);
                    error_count++;
                end
                if (o_release_old !== oldest.release_old) begin
                    $error("release_old: expected %0d, got %0d", oldest.release_old,
                           o_release_old);
                    error_count++;
                end
                if (o_copy_bytes !== oldest.copy_bytes) begin
                    $error("copy_bytes: expected %0d, got %0d", oldest.copy_bytes, o_copy_bytes);
                    error_count++;
                end
                if (o_request_size !== oldest.request_size) begin
                    $error("request_size: expected %0d, got %0d", oldest.request_size,
                           o_request_size);
                    error_count++;
                end
            end
        end
        if (no_idle) begin
            i_out_ready <= 1'b1;
        end else if (ready_hold > 0) begin
            ready_hold--;
        end else if ($urandom_range(0, 99) < 70) begin
            i_out_ready <= 1'b1;
            ready_hold = $urandom_range(0, 12);
        end else begin
            i_out_ready <= 1'b0;
            ready_hold = pick_gap();
        end
    end

    // Watchdog: a hung handshake ends the run as a failure.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    initial begin
        t_alloc_request r;
        t_alloc_outcome none;
        int             hot;
        int             other;
        int             n;

        none.action       = ACT_NOTHING;
        none.addr         = '0;
        none.release_old  = 1'b0;
        none.copy_bytes   = '0;
        none.request_size = '0;
        for (n = 0; n < CLASSES; n++) begin
            ring_head[n] = 0;
            ring_fill[n] = 0;
        end

        // Directed table, run from an empty cache. Rows marked typed carry their
        // outcome by hand; the rest depend on ring order and use the predictor.
        add_row(48'h123, 1'b0, 32'd64, 32'd0, 1, ACT_NOTHING, '0, '0);
        add_row('1, 1'b0, '1, 32'd0, 1, ACT_NOTHING, '0, '0);
        add_row('0, 1'b0, 32'd0, 32'd1, 1, ACT_SYS_REAL, '0, 33'd64);
        add_row('0, 1'b0, 32'd0, '1, 1, ACT_SYS_REAL, '0, 33'h1_0000_0000);
        add_row(48'hA000, 1'b1, 32'd100, 32'd128, 1, ACT_KEEP, 48'hA000, '0);
        add_row('1, 1'b1, '1, 32'hFFFF_FFC1, 1, ACT_KEEP, '1, '0);
        // Free of a size beyond the last class, and of size zero, goes to software.
        add_row(48'h5000, 1'b1, 32'd1025, 32'd0, 1, ACT_SYS_FREE, '0, '0);
        add_row(48'h5040, 1'b1, 32'd0, 32'd0, 1, ACT_SYS_FREE, '0, '0);
        // Old size zero never matches class zero of a one-byte request.
        add_row(48'h6000, 1'b1, 32'd0, 32'd1, 1, ACT_SYS_REAL, '0, 33'd64);
        add_row(48'hB000, 1'b1, 32'd1, 32'd0, 1, ACT_CFREE, '0, '0);
        add_row(48'hC000, 1'b1, 32'd1024, 32'd0, 1, ACT_CFREE, '0, '0);
        add_row('1, 1'b1, 32'd64, 32'd0, 1, ACT_CFREE, '0, '0);
        add_row('0, 1'b0, 32'd0, 32'd64, 0, ACT_NOTHING, '0, '0);
        add_row(48'hD000, 1'b1, 32'd2000, 32'd10, 0, ACT_NOTHING, '0, '0);
        add_row(48'hE000, 1'b1, 32'd500, 32'd1000, 0, ACT_NOTHING, '0, '0);
        add_row('0, 1'b0, 32'd0, 32'd33, 1, ACT_SYS_REAL, '0, 33'd64);
        add_row('0, 1'b0, 32'd0, 32'd449, 0, ACT_NOTHING, '0, '0);
        add_row(48'hF000, 1'b1, '1, 32'd0, 1, ACT_SYS_FREE, '0, '0);
        add_row(48'h0, 1'b1, 32'd1, '1, 1, ACT_SYS_REAL, '0, 33'h1_0000_0000);
        add_row(48'h7000, 1'b0, 32'd1, 32'd0, 1, ACT_NOTHING, '0, '0);

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed_rows[n])
            send_request(directed_rows[n].req, directed_rows[n].typed,
                         directed_rows[n].outcome);

        // Mixed random traffic, the first stretch with no idling on either side.
        hot = $urandom_range(0, CLASSES - 1);
        for (n = 0; n < MIXED_ITEMS; n++) begin
            no_idle = (n < 40);
            send_request(random_request(hot), 1'b0, none);
        end
        no_idle = 1'b0;

        // Let the block run dry before filling one ring to the brim.
        wait_all_results();
        while (ring_fill[hot] < SLOTS) begin
            r.addr     = rand_addr();
            r.present  = 1'b1;
            r.old_size = rand_size_in_class(hot);
            r.new_size = '0;
            send_request(r, 1'b0, none);
        end

        // With the hot ring full, frees overflow to software, and a cached block
        // handed out elsewhere leaves the old block for software to release.
        for (n = 0; n < 6; n++) begin
            other = (hot + 1 + $urandom_range(0, CLASSES - 2)) % CLASSES;
            r.addr     = rand_addr();
            r.present  = 1'b1;
            r.old_size = rand_size_in_class(hot);
            r.new_size = '0;
            send_request(r, 1'b0, none);
            r.old_size = rand_size_in_class(other);
            send_request(r, 1'b0, none);
            r.addr     = rand_addr();
            r.old_size = rand_size_in_class(hot);
            r.new_size = rand_size_in_class(other);
            send_request(r, 1'b0, none);
        end

        // Drain and refill around the full ring so its pointers wrap.
        wait_all_results();
        for (n = 0; n < MIXED_ITEMS; n++)
            send_request(random_request(hot), 1'b0, none);

        wait_all_results();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (error_count == 0 && expected_outcomes.size() == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
